/* rtl/core/grobc_pkg.sv */
package grobc_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_ACC,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } grobc_state_e;

  // Step codes of the squaring pass and of the slope pass
  typedef logic [2:0] step_t;

  localparam step_t SQ_OBS_X  = 3'd0;
  localparam step_t SQ_OBS_Y  = 3'd1;
  localparam step_t SQ_NODE_X = 3'd2;
  localparam step_t SQ_NODE_Y = 3'd3;
  localparam step_t SQ_GOAL_X = 3'd4;
  localparam step_t SQ_GOAL_Y = 3'd5;

  localparam step_t DIV_GOAL = 3'd0;
  localparam step_t DIV_C0   = 3'd1;
  localparam step_t DIV_C1   = 3'd2;
  localparam step_t DIV_C2   = 3'd3;
  localparam step_t DIV_C3   = 3'd4;

  localparam int unsigned SLOPE_W = 32;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 32'sh8000_0000;

  // Quotient magnitude limits before saturation
  localparam logic [SLOPE_W:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [SLOPE_W:0] NEG_LIMIT = 33'h0_8000_0000;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/grobc_in_if.sv */
interface grobc_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] goal_x;
  logic signed [COORD_BITS-1:0] goal_y;
  logic signed [COORD_BITS-1:0] node_x;
  logic signed [COORD_BITS-1:0] node_y;
  logic signed [COORD_BITS-1:0] obs_x;
  logic signed [COORD_BITS-1:0] obs_y;
  logic                         obstacle_present;
  logic                         last_obstacle;

  modport source (
    output valid, center_x, center_y, goal_x, goal_y, node_x, node_y,
           obs_x, obs_y, obstacle_present, last_obstacle,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, goal_x, goal_y, node_x, node_y,
           obs_x, obs_y, obstacle_present, last_obstacle,
    output ready
  );
endinterface

/* rtl/core/grobc_out_if.sv */
interface grobc_out_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (
    output valid, blocked,
    input  ready
  );

  modport sink (
    input  valid, blocked,
    output ready
  );
endinterface

/* rtl/core/grobc_div.sv */
module grobc_div
  import grobc_pkg::*;
#(
  parameter int unsigned MAG_W  = 18,
  parameter int unsigned FRAC_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  div_ctrl_t                 ctrl_i,
  input  logic [MAG_W-1:0]          num_i,
  input  logic [MAG_W-1:0]          den_i,
  output div_stat_t                 stat_o,
  output logic signed [SLOPE_W-1:0] slope_o
);

  localparam int unsigned NW = MAG_W + FRAC_W;
  localparam int unsigned QW = (NW > SLOPE_W + 1) ? NW : SLOPE_W + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]    quo_q;
  logic [MAG_W-1:0] rem_q;
  logic [MAG_W-1:0] den_q;
  logic             neg_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             fits;
  logic [QW-1:0]    qx;
  logic [SLOPE_W-1:0] qlow;

  // Restoring division: one quotient bit per cycle
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= {num_i, {FRAC_W{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= ctrl_i.neg;
    end else if (busy_q) begin
      rem_q <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign qx   = QW'(quo_q);
  assign qlow = qx[SLOPE_W-1:0];

  // Saturate to the signed 32-bit range
  always_comb begin
    if (neg_q) begin
      if (qx > QW'(NEG_LIMIT)) begin
        slope_o = SLOPE_MIN;
      end else begin
        slope_o = $signed(~qlow + 32'd1);
      end
    end else begin
      if (qx > QW'(POS_LIMIT)) begin
        slope_o = SLOPE_MAX;
      end else begin
        slope_o = $signed(qlow);
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* rtl/core/grid_ray_obstacle_block_check.sv */
// Ray obstacle check for one candidate node of a grid planner.
// item_i carries one obstacle cell per transaction together with the center,
// goal and node cells; last_obstacle closes a run. An item with
// obstacle_present low tests nothing (use it, marked last, for an empty list).
// result_o carries one transaction per run, sent for the item marked last:
// blocked is high when any obstacle of the run lies between center and goal
// in squared distance (beyond it lies the node) and its four half-cell
// corner slopes bracket the goal slope strictly.
// One item at a time: item_i.ready is high only while the sequencer idles.
// A real obstacle takes six squarings on the shared squarer, then five
// divisions (goal slope, four corner slopes) on one bit-serial divider at one
// quotient bit per cycle; a zero goal denominator saturates the goal slope
// without dividing. Items that fail the distance test skip the divisions;
// marker items go straight to the finish state.
// A finished result sits in an output register; a stalled receiver holds
// the block only when a further run ends before that result is taken.
// Reset clears the run flag, the sequencer and the output valid.
module grid_ray_obstacle_block_check
  import grobc_pkg::*;
#(
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned SLOPE_FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  grobc_in_if.sink      item_i,
  grobc_out_if.source   result_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned PW    = 2 * C + 2;
  localparam int unsigned DW    = 2 * C + 3;
  localparam int unsigned SW    = C + 3;
  localparam int unsigned MAG_W = C + 2;

  localparam logic signed [SW-1:0] SONE = SW'(1);

  grobc_state_e state_q, state_d;

  logic signed [C-1:0] cx_q, cy_q, gx_q, gy_q, nx_q, ny_q, ox_q, oy_q;
  logic                present_q;
  logic                last_q;

  step_t               sq_idx_q;
  step_t               div_idx_q;
  logic [PW-1:0]       prod_q;
  logic [DW-1:0]       dist_ob_q, dist_nd_q, dist_gl_q;
  logic                dist_ok_q;
  logic signed [SLOPE_W-1:0] kg_q;
  logic                lt_q, gt_q;
  logic                hit_seen_q;
  logic                out_valid_q;
  logic                out_blocked_q;

  logic signed [C:0]   dox, doy, dnx, dny, dgx, dgy;
  logic [C:0]          mul_op;
  logic [PW-1:0]       prod;
  logic signed [SW-1:0] ex, ey, gnum, gden;
  logic signed [SW-1:0] snum, sden;
  logic [MAG_W-1:0]    num_mag, den_mag;
  logic                goal_den_zero;
  logic                item_hit;
  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic                skip_div;

  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;
  logic signed [SLOPE_W-1:0] div_slope;

  assign in_fire  = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  // Offsets from the center
  assign dox = $signed({ox_q[C-1], ox_q}) - $signed({cx_q[C-1], cx_q});
  assign doy = $signed({oy_q[C-1], oy_q}) - $signed({cy_q[C-1], cy_q});
  assign dnx = $signed({nx_q[C-1], nx_q}) - $signed({cx_q[C-1], cx_q});
  assign dny = $signed({ny_q[C-1], ny_q}) - $signed({cy_q[C-1], cy_q});
  assign dgx = $signed({gx_q[C-1], gx_q}) - $signed({cx_q[C-1], cx_q});
  assign dgy = $signed({gy_q[C-1], gy_q}) - $signed({cy_q[C-1], cy_q});

  // Shared squarer operand
  always_comb begin
    case (sq_idx_q)
      SQ_OBS_X:  mul_op = dox[C] ? 1'(0) - dox : dox;
      SQ_OBS_Y:  mul_op = doy[C] ? 1'(0) - doy : doy;
      SQ_NODE_X: mul_op = dnx[C] ? 1'(0) - dnx : dnx;
      SQ_NODE_Y: mul_op = dny[C] ? 1'(0) - dny : dny;
      SQ_GOAL_X: mul_op = dgx[C] ? 1'(0) - dgx : dgx;
      SQ_GOAL_Y: mul_op = dgy[C] ? 1'(0) - dgy : dgy;
      default:   mul_op = '0;
    endcase
  end

  assign prod = PW'(mul_op) * PW'(mul_op);

  // Doubled obstacle offsets for the half-cell corners, and the goal offsets
  assign ex   = {dox[C], dox, 1'b0};
  assign ey   = {doy[C], doy, 1'b0};
  assign gnum = {{2{dgy[C]}}, dgy};
  assign gden = {{2{dgx[C]}}, dgx};

  always_comb begin
    case (div_idx_q)
      DIV_GOAL: begin snum = gnum;      sden = gden;      end
      DIV_C0:   begin snum = ey + SONE; sden = ex - SONE; end
      DIV_C1:   begin snum = ey + SONE; sden = ex + SONE; end
      DIV_C2:   begin snum = ey - SONE; sden = ex + SONE; end
      DIV_C3:   begin snum = ey - SONE; sden = ex - SONE; end
      default:  begin snum = gnum;      sden = gden;      end
    endcase
  end

  assign num_mag       = MAG_W'(snum[SW-1] ? -snum : snum);
  assign den_mag       = MAG_W'(sden[SW-1] ? -sden : sden);
  assign goal_den_zero = (gden == '0);
  assign skip_div      = (div_idx_q == DIV_GOAL) && goal_den_zero;
  assign item_hit      = present_q && dist_ok_q && lt_q && gt_q;

  grobc_div #(
    .MAG_W  (MAG_W),
    .FRAC_W (SLOPE_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .stat_o  (div_stat),
    .slope_o (div_slope)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = item_i.obstacle_present ? S_SQ_MUL : S_FINISH;
        end
      end
      S_SQ_MUL: state_d = S_SQ_ACC;
      S_SQ_ACC: state_d = (sq_idx_q == SQ_GOAL_Y) ? S_CHECK : S_SQ_MUL;
      S_CHECK: begin
        state_d = (dist_nd_q > dist_ob_q && dist_nd_q < dist_gl_q) ?
                  S_DIV_START : S_FINISH;
      end
      S_DIV_START: begin
        if (!skip_div) begin
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = (div_idx_q == DIV_C3) ? S_FINISH : S_DIV_START;
        end
      end
      S_FINISH: begin
        if (!last_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_i.ready   = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.neg   = snum[SW-1] ^ sden[SW-1];
    out_load       = 1'b0;
    unique case (state_q)
      S_IDLE:      item_i.ready = 1'b1;
      S_DIV_START: div_ctrl.start = !skip_div;
      S_FINISH:    out_load = last_q && out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FINISH) begin
        if (!last_q) begin
          hit_seen_q <= hit_seen_q | item_hit;
        end else if (out_free) begin
          hit_seen_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cx_q      <= item_i.center_x;
      cy_q      <= item_i.center_y;
      gx_q      <= item_i.goal_x;
      gy_q      <= item_i.goal_y;
      nx_q      <= item_i.node_x;
      ny_q      <= item_i.node_y;
      ox_q      <= item_i.obs_x;
      oy_q      <= item_i.obs_y;
      present_q <= item_i.obstacle_present;
      last_q    <= item_i.last_obstacle;
      sq_idx_q  <= SQ_OBS_X;
      div_idx_q <= DIV_GOAL;
      dist_ok_q <= 1'b0;
      lt_q      <= 1'b0;
      gt_q      <= 1'b0;
    end
    if (state_q == S_SQ_MUL) begin
      prod_q <= prod;
    end
    if (state_q == S_SQ_ACC) begin
      sq_idx_q <= sq_idx_q + step_t'(1);
      case (sq_idx_q)
        SQ_OBS_X:  dist_ob_q <= DW'(prod_q);
        SQ_OBS_Y:  dist_ob_q <= dist_ob_q + DW'(prod_q);
        SQ_NODE_X: dist_nd_q <= DW'(prod_q);
        SQ_NODE_Y: dist_nd_q <= dist_nd_q + DW'(prod_q);
        SQ_GOAL_X: dist_gl_q <= DW'(prod_q);
        SQ_GOAL_Y: dist_gl_q <= dist_gl_q + DW'(prod_q);
        default:   ;
      endcase
    end
    if (state_q == S_CHECK) begin
      dist_ok_q <= dist_nd_q > dist_ob_q && dist_nd_q < dist_gl_q;
    end
    // Zero goal denominator: saturate and advance without dividing
    if (state_q == S_DIV_START && skip_div) begin
      kg_q      <= SLOPE_MAX;
      div_idx_q <= div_idx_q + step_t'(1);
    end
    if (state_q == S_DIV_WAIT && div_stat.done) begin
      div_idx_q <= div_idx_q + step_t'(1);
      if (div_idx_q == DIV_GOAL) begin
        kg_q <= div_slope;
      end else begin
        lt_q <= lt_q | (div_slope < kg_q);
        gt_q <= gt_q | (div_slope > kg_q);
      end
    end
    if (out_load) begin
      out_blocked_q <= hit_seen_q | item_hit;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.blocked = out_blocked_q;

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> !div_stat.busy)
    else $error("input ready while the divider is busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV_WAIT)
    else $error("divider finished outside the wait state");

  a_div_needs_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |-> present_q && dist_ok_q)
    else $error("division started for an item that failed the distance test");

  a_run_flag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !hit_seen_q && out_valid_q)
    else $error("run flag not cleared after the result was loaded");

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int          N_ITEMS    = 1800;
  localparam int          CYCLE_LIMIT = 2_500_000;
  localparam int          DRAIN_CYCLES = 250;

  typedef struct {
    logic signed [COORD_BITS-1:0] cx, cy, gx, gy, nx, ny, ox, oy;
    logic                         present;
    logic                         last;
  } ray_item_t;

  // Tracks the sticky hit of the current run and the verdicts still owed.
  class ray_verdict_board;
    bit   run_hit;
    bit   verdicts_q[$];
    int   errors;

    function longint sq_dist(longint dx, longint dy);
      return dx * dx + dy * dy;
    endfunction

    // Fixed-point quotient, truncated toward zero, saturated to 32 bits.
    function longint ray_slope(longint num, longint den);
      longint unsigned n, d, q;
      if (den == 0) return 64'sh7FFF_FFFF;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n << FRAC_BITS) / d;
      if ((num < 0) != (den < 0)) begin
        if (q > 64'h8000_0000) return -64'sh8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) return 64'sh7FFF_FFFF;
      return longint'(q);
    endfunction

    function bit obstacle_in_ray(ray_item_t it);
      longint cx, cy, gx, gy, nx, ny, ox, oy;
      longint d_obs, d_node, d_goal, ex, ey, kmin, kmax, kg;
      longint k[4];
      cx = it.cx; cy = it.cy; gx = it.gx; gy = it.gy;
      nx = it.nx; ny = it.ny; ox = it.ox; oy = it.oy;
      d_obs  = sq_dist(cx - ox, cy - oy);
      d_node = sq_dist(cx - nx, cy - ny);
      d_goal = sq_dist(cx - gx, cy - gy);
      if (!(d_node > d_obs && d_node < d_goal)) return 1'b0;
      ex = 2 * (ox - cx);
      ey = 2 * (oy - cy);
      k[0] = ray_slope(ey + 1, ex - 1);
      k[1] = ray_slope(ey + 1, ex + 1);
      k[2] = ray_slope(ey - 1, ex + 1);
      k[3] = ray_slope(ey - 1, ex - 1);
      kmin = k[0];
      kmax = k[0];
      for (int i = 1; i < 4; i++) begin
        if (k[i] < kmin) kmin = k[i];
        if (k[i] > kmax) kmax = k[i];
      end
      kg = ray_slope(gy - cy, gx - cx);
      return (kg > kmin) && (kg < kmax);
    endfunction

    function void note_item(ray_item_t it);
      if (it.present && obstacle_in_ray(it)) run_hit = 1'b1;
      if (it.last) begin
        verdicts_q.push_back(run_hit);
        run_hit = 1'b0;
      end
    endfunction

    function void check_result(logic blocked);
      bit want;
      if (verdicts_q.size() == 0) begin
        $error("blocked: no verdict expected, actual %0b", blocked);
        errors++;
        return;
      end
      want = verdicts_q.pop_front();
      if (blocked !== want) begin
        $error("blocked: expected %0b, actual %0b", want, blocked);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   items_sent;

  ray_verdict_board board = new();

  grobc_in_if #(.COORD_BITS(COORD_BITS)) item_if ();
  grobc_out_if result_if ();

  grid_ray_obstacle_block_check #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) board.check_result(result_if.blocked);
  end

  function automatic int srange(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return srange(1, 3);
    return srange(10, 60);
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 3))
      0: return srange(-32768, 32767);
      1: return srange(-100, 100);
      2: return srange(-32768, -32700);
      default: return srange(32700, 32767);
    endcase
  endfunction

  function automatic ray_item_t make_item(int cx, int cy, int gx, int gy, int nx, int ny,
                                          int ox, int oy, bit present, bit last);
    ray_item_t it;
    it.cx = 16'(cx); it.cy = 16'(cy);
    it.gx = 16'(gx); it.gy = 16'(gy);
    it.nx = 16'(nx); it.ny = 16'(ny);
    it.ox = 16'(ox); it.oy = 16'(oy);
    it.present = present;
    it.last    = last;
    return it;
  endfunction

  task automatic send_item(input ray_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid            <= 1'b1;
    item_if.center_x         <= it.cx;
    item_if.center_y         <= it.cy;
    item_if.goal_x           <= it.gx;
    item_if.goal_y           <= it.gy;
    item_if.node_x           <= it.nx;
    item_if.node_y           <= it.ny;
    item_if.obs_x            <= it.ox;
    item_if.obs_y            <= it.oy;
    item_if.obstacle_present <= it.present;
    item_if.last_obstacle    <= it.last;
    do @(posedge clk_i); while (!item_if.ready);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic drive_result_ready();
    int hold;
    forever begin
      result_if.ready <= 1'b1;
      // occasionally keep ready high for a long stretch
      hold = ($urandom_range(0, 9) == 0) ? srange(300, 1500) : srange(1, 30);
      repeat (hold) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_directed();
    // empty list
    send_item(make_item(0, 0, 10, 0, 7, 0, 5, 0, 0, 1));
    // obstacle on the ray, node beyond it
    send_item(make_item(0, 0, 10, 0, 7, 0, 5, 0, 1, 1));
    // node nearer than the obstacle, node past the goal, node level with obstacle
    send_item(make_item(0, 0, 10, 0, 3, 0, 5, 0, 1, 1));
    send_item(make_item(0, 0, 10, 0, 12, 0, 5, 0, 1, 1));
    send_item(make_item(0, 0, 10, 0, 5, 0, 5, 0, 1, 1));
    // vertical goal: goal slope saturates
    send_item(make_item(0, 0, 0, 10, 0, 7, 0, 5, 1, 1));
    // goal on the center
    send_item(make_item(3, -4, 3, -4, 3, -4, 3, -4, 1, 1));
    // corner slopes saturate both ways, goal just off vertical
    send_item(make_item(0, 0, 0, 32767, 0, 31000, 0, 30000, 1, 1));
    send_item(make_item(0, 0, 1, 32767, 0, 31000, 0, 30000, 1, 1));
    // sticky hit over a run: marker, hit, miss, marker last
    send_item(make_item(0, 0, 10, 0, 7, 0, 5, 0, 0, 0));
    send_item(make_item(0, 0, 10, 10, 7, 7, 5, 5, 1, 0));
    send_item(make_item(0, 0, 10, 0, 3, 0, 5, 0, 1, 0));
    send_item(make_item(0, 0, 10, 0, 7, 0, 5, 0, 0, 1));
    // flag must be clear for the next run
    send_item(make_item(0, 0, 10, 0, 3, 0, 5, 0, 1, 1));
    // extremes of the coordinate range
    send_item(make_item(-32768, -32768, 32767, 32767, 16000, 16000, 0, 0, 1, 1));
    send_item(make_item(32767, 32767, -32768, -32768, -16000, -16000, 0, 0, 1, 1));
    send_item(make_item(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 1, 1));
    send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1, 1, 1));
    // center and goal change within one run
    send_item(make_item(100, 100, 110, 100, 107, 100, 105, 100, 1, 0));
    send_item(make_item(-50, 20, -50, 40, -50, 35, -50, 30, 1, 1));
    // negative slopes, goal slope hits a corner slope exactly
    send_item(make_item(0, 0, -20, 20, -15, 15, -10, 10, 1, 1));
    send_item(make_item(0, 0, 11, 1, 8, 1, 5, 0, 1, 1));
  endtask

  task automatic send_random_run();
    ray_item_t it;
    int run_len, reach, kind, t, s;
    int cx, cy, dx, dy;
    run_len = ($urandom_range(0, 9) < 8) ? srange(1, 4) : srange(5, 8);
    case ($urandom_range(0, 3))
      0: reach = 4;
      1: reach = 64;
      2: reach = 2000;
      default: reach = 32767;
    endcase
    cx = pick_center();
    cy = pick_center();
    dx = srange(-reach, reach);
    dy = srange(-reach, reach);
    for (int i = 0; i < run_len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        cx = pick_center();
        cy = pick_center();
        dx = srange(-reach, reach);
        dy = srange(-reach, reach);
      end
      if (kind < 75) begin
        t = srange(0, 1000);
        s = srange(0, 1100);
        it = make_item(cx, cy, cx + dx, cy + dy,
                       cx + dx * s / 1000 + srange(-1, 1), cy + dy * s / 1000 + srange(-1, 1),
                       cx + dx * t / 1000 + srange(-1, 1), cy + dy * t / 1000 + srange(-1, 1),
                       1'b1, 1'b0);
      end else if (kind < 87) begin
        it = make_item(cx, cy, cx + dx, cy + dy, srange(-32768, 32767), srange(-32768, 32767),
                       srange(-32768, 32767), srange(-32768, 32767), 1'b0, 1'b0);
      end else begin
        it = make_item(srange(-32768, 32767), srange(-32768, 32767), srange(-32768, 32767),
                       srange(-32768, 32767), srange(-32768, 32767), srange(-32768, 32767),
                       srange(-32768, 32767), srange(-32768, 32767), $urandom_range(0, 1),
                       1'b0);
      end
      it.last = (i == run_len - 1);
      send_item(it);
    end
  endtask

  initial begin
    cycles                   = 0;
    items_sent               = 0;
    rst_ni                   = 1'b0;
    item_if.valid            = 1'b0;
    item_if.center_x         = '0;
    item_if.center_y         = '0;
    item_if.goal_x           = '0;
    item_if.goal_y           = '0;
    item_if.node_x           = '0;
    item_if.node_y           = '0;
    item_if.obs_x            = '0;
    item_if.obs_y            = '0;
    item_if.obstacle_present = 1'b0;
    item_if.last_obstacle    = 1'b0;
    result_if.ready          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      drive_result_ready();
    join_none
    send_directed();
    while (items_sent < N_ITEMS) send_random_run();
    item_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
